@@ src/lffg_pkg.sv @@
// Shared types, constants and helpers of the lagged Fibonacci fraction generator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lffg_pkg;

   localparam int LONG_LAG       = 100;
   localparam int SHORT_LAG      = 37;
   localparam int LAG_GAP        = LONG_LAG - SHORT_LAG;
   localparam int SCRATCH_LEN    = LONG_LAG + LONG_LAG - 1;
   localparam int BATCH_LEN_DEF  = 1009;
   localparam int STREAM_SEP_DEF = 70;
   localparam int FRAC_W         = 52;
   localparam int SEED_W         = 30;
   localparam int RING_AW        = 7;
   localparam int SCR_AW         = 8;
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_AW       = 1;

   localparam logic ACTION_DRAW = 1'b0;
   localparam logic ACTION_SEED = 1'b1;

   typedef struct packed {
      logic              do_seed;
      logic              do_draw;
      logic [SEED_W-1:0] seed;
   } lffg_cmd_type;

   typedef struct packed {
      logic               en;
      logic [RING_AW-1:0] addr;
      logic [FRAC_W-1:0]  data;
   } lffg_ring_wr_type;

   typedef struct packed {
      logic              start;
      logic [SEED_W-1:0] seed;
   } lffg_seed_req_type;

   // sum of two fractions mod 1
   function automatic logic [FRAC_W-1:0] add_frac(input logic [FRAC_W-1:0] a,
                                                 input logic [FRAC_W-1:0] b);
      logic [FRAC_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[FRAC_W-1:0];
   endfunction

endpackage

`default_nettype wire

@@ src/lffg_if.sv @@
// Channel interfaces of the generator: request (action, seed) and response (fraction).
// Depends on lffg_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface lffg_req_if import lffg_pkg::*;;
   logic              valid;
   logic              ready;
   logic              action;
   logic [SEED_W-1:0] seed_value;

   modport source (output valid, output action, output seed_value, input ready);
   modport sink   (input valid, input action, input seed_value, output ready);
endinterface

interface lffg_rsp_if import lffg_pkg::*;;
   logic              valid;
   logic              ready;
   logic [FRAC_W-1:0] fraction;

   modport source (output valid, output fraction, input ready);
   modport sink   (input valid, input fraction, output ready);
endinterface

`default_nettype wire

@@ src/lffg_front.sv @@
// Front end: accepts request transactions and turns them into back-end commands.
// Depends on lffg_pkg and lffg_if; tracks whether the generator was ever seeded.
`timescale 1ns / 1ps
`default_nettype none

module lffg_front import lffg_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   lffg_req_if.sink    req,
   output lffg_cmd_type cmd,
   output logic        cmd_valid,
   input  wire logic   cmd_ready
);

   logic needs_seed_ff;
   logic needs_seed_in;
   logic accept;

   assign accept    = req.valid && cmd_ready;
   assign req.ready = cmd_ready;
   assign cmd_valid = req.valid;

   always_comb begin
      needs_seed_in = needs_seed_ff;
      if (req.action == ACTION_SEED) begin
         cmd.do_seed = 1'b1;
         cmd.do_draw = 1'b0;
         cmd.seed    = req.seed_value;
      end else begin
         // draw before any seed: seed with one first
         cmd.do_seed = needs_seed_ff;
         cmd.do_draw = 1'b1;
         cmd.seed    = SEED_W'(1);
      end
      if (accept) begin
         needs_seed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         needs_seed_ff <= 1'b1;
      end else begin
         needs_seed_ff <= needs_seed_in;
      end
   end

endmodule

`default_nettype wire

@@ src/lffg_queue.sv @@
// Short command queue between front and back end.
// Depends on lffg_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module lffg_queue import lffg_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lffg_cmd_type  in_cmd,
   input  wire logic          in_valid,
   output logic               in_ready,
   output lffg_cmd_type       out_cmd,
   output logic               out_valid,
   input  wire logic          out_ready
);

   lffg_cmd_type        q_mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;
   logic                push, pop;

   assign in_ready  = count_ff != (QUEUE_AW+1)'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign out_cmd   = q_mem[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= in_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

@@ src/lffg_seed.sv @@
// Seeding sequencer: bootstrap, square, fold and multiply-by-z passes over a scratch memory,
// then streams the 100 seeded lag values out. Depends on lffg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lffg_seed import lffg_pkg::*; #(
   parameter int STREAM_SEPARATION = STREAM_SEP_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lffg_seed_req_type seed_req,
   output lffg_ring_wr_type       ring_wr,
   output logic                   seed_done
);

   localparam int T_W = $clog2(STREAM_SEPARATION + 1);
   localparam logic [T_W-1:0] T_INIT = T_W'(STREAM_SEPARATION - 1);

   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_BOOT     = 5'd1;
   localparam logic [4:0] S_LOOP     = 5'd2;
   localparam logic [4:0] S_SQ_RD    = 5'd3;
   localparam logic [4:0] S_SQ_WR    = 5'd4;
   localparam logic [4:0] S_NG_RD    = 5'd5;
   localparam logic [4:0] S_NG_WR    = 5'd6;
   localparam logic [4:0] S_AD_RD    = 5'd7;
   localparam logic [4:0] S_AD_CHK   = 5'd8;
   localparam logic [4:0] S_AD_WA    = 5'd9;
   localparam logic [4:0] S_AD_WB    = 5'd10;
   localparam logic [4:0] S_MZ_RD    = 5'd11;
   localparam logic [4:0] S_MZ_WR    = 5'd12;
   localparam logic [4:0] S_MZ_TOP   = 5'd13;
   localparam logic [4:0] S_MZ_TOPWR = 5'd14;
   localparam logic [4:0] S_MZ_FIXWR = 5'd15;
   localparam logic [4:0] S_UPD      = 5'd16;
   localparam logic [4:0] S_OUT_RD   = 5'd17;
   localparam logic [4:0] S_OUT_WR   = 5'd18;

   // bit FRAC_W holds the low bit flag, the rest the value
   logic [FRAC_W:0]       scr_mem [SCRATCH_LEN];
   logic [FRAC_W:0]       rd_data_ff;

   logic [4:0]            state_ff, state_in;
   logic [SCR_AW-1:0]     j_ff, j_in;
   logic [SEED_W-1:0]     s_ff, s_in;
   logic [T_W-1:0]        t_ff, t_in;
   logic [FRAC_W-1:0]     ss_ff, ss_in;
   logic [FRAC_W-1:0]     uj_ff, uj_in;

   logic                  rd_en, wr_en;
   logic [SCR_AW-1:0]     rd_addr, wr_addr;
   logic [FRAC_W:0]       wr_data;
   logic [FRAC_W-1:0]     rd_val;
   logic                  rd_lo;
   logic [FRAC_W:0]       ss_dbl;
   logic [FRAC_W-1:0]     ss_next;
   logic [31:0]           ss_start;
   logic [FRAC_W-1:0]     rd_sum;

   assign rd_val   = rd_data_ff[FRAC_W-1:0];
   assign rd_lo    = rd_data_ff[FRAC_W];
   assign rd_sum   = add_frac(rd_val, uj_ff);
   assign ss_dbl   = {ss_ff, 1'b0};
   assign ss_next  = ss_dbl[FRAC_W] ? ss_dbl[FRAC_W-1:0] + FRAC_W'(2) : ss_dbl[FRAC_W-1:0];
   assign ss_start = {({1'b0, seed_req.seed} + 31'd2), 1'b0};

   always_comb begin
      state_in  = state_ff;
      j_in      = j_ff;
      s_in      = s_ff;
      t_in      = t_ff;
      ss_in     = ss_ff;
      uj_in     = uj_ff;
      rd_en     = 1'b0;
      rd_addr   = j_ff;
      wr_en     = 1'b0;
      wr_addr   = j_ff;
      wr_data   = rd_data_ff;
      ring_wr   = '0;
      seed_done = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (seed_req.start) begin
               j_in     = '0;
               s_in     = seed_req.seed;
               t_in     = T_INIT;
               ss_in    = {{(FRAC_W-32){1'b0}}, ss_start};
               state_in = S_BOOT;
            end
         end
         S_BOOT: begin
            wr_en = 1'b1;
            if (j_ff < SCR_AW'(LONG_LAG)) begin
               ss_in = ss_next;
               if (j_ff == SCR_AW'(1)) begin
                  wr_data = {1'b1, ss_ff | FRAC_W'(1)};
               end else begin
                  wr_data = {1'b0, ss_ff};
               end
            end else begin
               wr_data = '0;
            end
            if (j_ff == SCR_AW'(SCRATCH_LEN - 1)) begin
               state_in = S_LOOP;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         S_LOOP: begin
            if (t_ff == '0) begin
               j_in     = '0;
               state_in = S_OUT_RD;
            end else begin
               j_in     = SCR_AW'(LONG_LAG - 1);
               state_in = S_SQ_RD;
            end
         end
         // square: spread entries to even places
         S_SQ_RD: begin
            rd_en    = 1'b1;
            state_in = S_SQ_WR;
         end
         S_SQ_WR: begin
            wr_en   = 1'b1;
            wr_addr = {j_ff[SCR_AW-2:0], 1'b0};
            if (j_ff == SCR_AW'(1)) begin
               j_in     = SCR_AW'(SCRATCH_LEN - 1);
               state_in = S_NG_RD;
            end else begin
               j_in     = j_ff - 1'b1;
               state_in = S_SQ_RD;
            end
         end
         S_NG_RD: begin
            rd_en    = 1'b1;
            state_in = S_NG_WR;
         end
         S_NG_WR: begin
            wr_en   = 1'b1;
            wr_addr = SCR_AW'(SCRATCH_LEN) - j_ff;
            wr_data = {1'b0, rd_val - {{(FRAC_W-1){1'b0}}, rd_lo}};
            if (j_ff == SCR_AW'(LAG_GAP + 1)) begin
               j_in     = SCR_AW'(SCRATCH_LEN - 1);
               state_in = S_AD_RD;
            end else begin
               j_in     = j_ff - SCR_AW'(2);
               state_in = S_NG_RD;
            end
         end
         // fold the upper half back into the lower half
         S_AD_RD: begin
            rd_en    = 1'b1;
            state_in = S_AD_CHK;
         end
         S_AD_CHK: begin
            uj_in = rd_val;
            if (rd_lo) begin
               rd_en    = 1'b1;
               rd_addr  = j_ff - SCR_AW'(LAG_GAP);
               state_in = S_AD_WA;
            end else if (j_ff == SCR_AW'(LONG_LAG)) begin
               j_in     = SCR_AW'(LONG_LAG);
               state_in = s_ff[0] ? S_MZ_RD : S_UPD;
            end else begin
               j_in     = j_ff - 1'b1;
               state_in = S_AD_RD;
            end
         end
         S_AD_WA: begin
            wr_en    = 1'b1;
            wr_addr  = j_ff - SCR_AW'(LAG_GAP);
            wr_data  = {~rd_lo, rd_sum};
            rd_en    = 1'b1;
            rd_addr  = j_ff - SCR_AW'(LONG_LAG);
            state_in = S_AD_WB;
         end
         S_AD_WB: begin
            wr_en   = 1'b1;
            wr_addr = j_ff - SCR_AW'(LONG_LAG);
            wr_data = {~rd_lo, rd_sum};
            if (j_ff == SCR_AW'(LONG_LAG)) begin
               j_in     = SCR_AW'(LONG_LAG);
               state_in = s_ff[0] ? S_MZ_RD : S_UPD;
            end else begin
               j_in     = j_ff - 1'b1;
               state_in = S_AD_RD;
            end
         end
         // multiply by z: shift up one place
         S_MZ_RD: begin
            rd_en    = 1'b1;
            rd_addr  = j_ff - 1'b1;
            state_in = S_MZ_WR;
         end
         S_MZ_WR: begin
            wr_en = 1'b1;
            if (j_ff == SCR_AW'(1)) begin
               state_in = S_MZ_TOP;
            end else begin
               j_in     = j_ff - 1'b1;
               state_in = S_MZ_RD;
            end
         end
         S_MZ_TOP: begin
            rd_en    = 1'b1;
            rd_addr  = SCR_AW'(LONG_LAG);
            state_in = S_MZ_TOPWR;
         end
         S_MZ_TOPWR: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            uj_in   = rd_val;
            if (rd_lo) begin
               rd_en    = 1'b1;
               rd_addr  = SCR_AW'(SHORT_LAG);
               state_in = S_MZ_FIXWR;
            end else begin
               state_in = S_UPD;
            end
         end
         S_MZ_FIXWR: begin
            wr_en    = 1'b1;
            wr_addr  = SCR_AW'(SHORT_LAG);
            wr_data  = {~rd_lo, rd_sum};
            state_in = S_UPD;
         end
         S_UPD: begin
            if (s_ff != '0) begin
               s_in = s_ff >> 1;
            end else begin
               t_in = t_ff - 1'b1;
            end
            state_in = S_LOOP;
         end
         S_OUT_RD: begin
            rd_en    = 1'b1;
            state_in = S_OUT_WR;
         end
         S_OUT_WR: begin
            ring_wr.en   = 1'b1;
            ring_wr.data = rd_val;
            if (j_ff < SCR_AW'(SHORT_LAG)) begin
               ring_wr.addr = RING_AW'(j_ff + SCR_AW'(LAG_GAP));
            end else begin
               ring_wr.addr = RING_AW'(j_ff - SCR_AW'(SHORT_LAG));
            end
            if (j_ff == SCR_AW'(LONG_LAG - 1)) begin
               seed_done = 1'b1;
               state_in  = S_IDLE;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_OUT_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         scr_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= scr_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      j_ff  <= j_in;
      s_ff  <= s_in;
      t_ff  <= t_in;
      ss_ff <= ss_in;
      uj_ff <= uj_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

@@ src/lffg_back.sv @@
// Back end: runs seed and draw commands, owns the lag ring, the batch store and the
// response register. Depends on lffg_pkg, lffg_if and the lffg_seed sequencer outputs.
`timescale 1ns / 1ps
`default_nettype none

module lffg_back import lffg_pkg::*; #(
   parameter int BATCH_LENGTH = BATCH_LEN_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire lffg_cmd_type      cmd,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   output lffg_seed_req_type      seed_req,
   input  wire lffg_ring_wr_type  seed_wr,
   input  wire logic              seed_done,
   lffg_rsp_if.source             rsp
);

   localparam int CNT_W = $clog2(BATCH_LENGTH + 1);

   localparam logic [2:0] B_IDLE = 3'd0;
   localparam logic [2:0] B_SEED = 3'd1;
   localparam logic [2:0] B_DRAW = 3'd2;
   localparam logic [2:0] B_REF  = 3'd3;
   localparam logic [2:0] B_OUT  = 3'd4;

   logic [FRAC_W-1:0]  ring_mem  [LONG_LAG];
   logic [FRAC_W-1:0]  batch_mem [LONG_LAG];

   logic [2:0]         state_ff, state_in;
   logic               draw_ff, draw_in;
   logic [RING_AW-1:0] base_ff, base_in;
   logic [RING_AW-1:0] batch_pos_ff, batch_pos_in;
   logic [CNT_W-1:0]   step_ff, step_in;
   logic [RING_AW-1:0] wp_ff, wp_in;
   logic [RING_AW-1:0] sp_ff, sp_in;
   logic               pv_ff, pv_in;
   logic [RING_AW-1:0] pw_ff, pw_in;
   logic               pbv_ff, pbv_in;
   logic [RING_AW-1:0] pbi_ff, pbi_in;
   logic [FRAC_W-1:0]  ra_ff, rb_ff;
   logic [FRAC_W-1:0]  batch_rd_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [FRAC_W-1:0]  rsp_data_ff, rsp_data_in;

   logic               ring_rd_en, batch_rd_en;
   logic               ring_we;
   logic [RING_AW-1:0] ring_wa;
   logic [FRAC_W-1:0]  ring_wd;
   logic [RING_AW:0]   sp_sum;
   logic [RING_AW-1:0] sp_start;

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.fraction = rsp_data_ff;
   assign cmd_ready    = state_ff == B_IDLE;

   assign sp_sum   = {1'b0, base_ff} + (RING_AW+1)'(LAG_GAP);
   assign sp_start = (sp_sum >= (RING_AW+1)'(LONG_LAG)) ?
                     RING_AW'(sp_sum - (RING_AW+1)'(LONG_LAG)) : RING_AW'(sp_sum);

   // seeder and refill never write in the same cycle
   assign ring_we = pv_ff || seed_wr.en;
   assign ring_wa = pv_ff ? pw_ff : seed_wr.addr;
   assign ring_wd = pv_ff ? add_frac(ra_ff, rb_ff) : seed_wr.data;

   always_comb begin
      state_in     = state_ff;
      draw_in      = draw_ff;
      base_in      = base_ff;
      batch_pos_in = batch_pos_ff;
      step_in      = step_ff;
      wp_in        = wp_ff;
      sp_in        = sp_ff;
      pv_in        = 1'b0;
      pw_in        = pw_ff;
      pbv_in       = 1'b0;
      pbi_in       = pbi_ff;
      ring_rd_en   = 1'b0;
      batch_rd_en  = 1'b0;
      seed_req     = '0;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         B_IDLE: begin
            if (cmd_valid) begin
               draw_in = cmd.do_draw;
               if (cmd.do_seed) begin
                  seed_req.start = 1'b1;
                  seed_req.seed  = cmd.seed;
                  base_in        = '0;
                  state_in       = B_SEED;
               end else begin
                  state_in = B_DRAW;
               end
            end
         end
         B_SEED: begin
            if (seed_done) begin
               state_in = draw_ff ? B_DRAW : B_IDLE;
            end
         end
         B_DRAW: begin
            if (batch_pos_ff >= RING_AW'(LONG_LAG)) begin
               step_in  = '0;
               wp_in    = base_ff;
               sp_in    = sp_start;
               state_in = B_REF;
            end else begin
               batch_rd_en = 1'b1;
               state_in    = B_OUT;
            end
         end
         // one lag step per cycle; in the first LONG_LAG steps the oldest value also goes to the batch
         B_REF: begin
            if (step_ff != CNT_W'(BATCH_LENGTH)) begin
               ring_rd_en = 1'b1;
               pv_in      = 1'b1;
               pw_in      = wp_ff;
               pbv_in     = step_ff < CNT_W'(LONG_LAG);
               pbi_in     = step_ff[RING_AW-1:0];
               step_in    = step_ff + 1'b1;
               wp_in      = (wp_ff == RING_AW'(LONG_LAG - 1)) ? '0 : wp_ff + 1'b1;
               sp_in      = (sp_ff == RING_AW'(LONG_LAG - 1)) ? '0 : sp_ff + 1'b1;
            end else begin
               base_in      = wp_ff;
               batch_pos_in = '0;
               state_in     = B_DRAW;
            end
         end
         B_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = batch_rd_ff;
               batch_pos_in = batch_pos_ff + 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[ring_wa] <= ring_wd;
      end
      if (ring_rd_en) begin
         ra_ff <= ring_mem[wp_ff];
         rb_ff <= ring_mem[sp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (pv_ff && pbv_ff) begin
         batch_mem[pbi_ff] <= ra_ff;
      end
      if (batch_rd_en) begin
         batch_rd_ff <= batch_mem[batch_pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      draw_ff     <= draw_in;
      step_ff     <= step_in;
      wp_ff       <= wp_in;
      sp_ff       <= sp_in;
      pw_ff       <= pw_in;
      pbi_ff      <= pbi_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         state_ff     <= B_IDLE;
         base_ff      <= '0;
         batch_pos_ff <= RING_AW'(LONG_LAG);
         pv_ff        <= 1'b0;
         pbv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         batch_pos_ff <= batch_pos_in;
         pv_ff        <= pv_in;
         pbv_ff       <= pbv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_ring_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(pv_ff && seed_wr.en))
      else $error("lag ring written by refill and seeder at once");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      batch_pos_ff <= RING_AW'(LONG_LAG))
      else $error("batch position out of range");

   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == B_REF |-> (wp_ff < RING_AW'(LONG_LAG) && sp_ff < RING_AW'(LONG_LAG)))
      else $error("ring pointer out of range during refill");

   a_rsp_after_draw: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == B_OUT && batch_pos_ff != '0))
      else $error("response raised outside a draw");

endmodule

`default_nettype wire

@@ src/lagged_fibonacci_fraction_generator.sv @@
// Draw from the current batch, one draw at a time. A draw that finds the batch empty first
// runs BATCH_LENGTH lag steps (one ring step per cycle) to refill the ring and the batch of
// LONG_LAG values. Seeding: scratch fill, then the passes, then copy-out of the lag values;
// passes = STREAM_SEPARATION-1 plus the seed's bit length. Synchronous reset clears the
// state machines, queue, seed flag, batch position and valid flags, not every control
// register; lag ring, batch and scratch memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module lagged_fibonacci_fraction_generator import lffg_pkg::*; #(
   parameter int BATCH_LENGTH      = BATCH_LEN_DEF,
   parameter int STREAM_SEPARATION = STREAM_SEP_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   lffg_req_if.sink   req,
   lffg_rsp_if.source rsp
);

   lffg_cmd_type      front_cmd, back_cmd;
   logic              front_valid, front_ready;
   logic              back_valid, back_ready;
   lffg_seed_req_type seed_req;
   lffg_ring_wr_type  seed_wr;
   logic              seed_done;

   lffg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (front_cmd),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready)
   );

   lffg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_cmd    (front_cmd),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_cmd   (back_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready)
   );

   lffg_seed #(
      .STREAM_SEPARATION (STREAM_SEPARATION)
   ) u_seed (
      .clock     (clock),
      .reset     (reset),
      .seed_req  (seed_req),
      .ring_wr   (seed_wr),
      .seed_done (seed_done)
   );

   lffg_back #(
      .BATCH_LENGTH (BATCH_LENGTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .seed_req  (seed_req),
      .seed_wr   (seed_wr),
      .seed_done (seed_done),
      .rsp       (rsp)
   );

endmodule

`default_nettype wire
